// File: sv/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_e;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    case_e              case_taken;
    logic               bad_input;
  } out_word_t;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned NUM_W  = 17;
  localparam int unsigned QBITS  = 15;

endpackage

// File: sv/rmq_isqrt.sv
`timescale 1ns / 1ps

module rmq_isqrt import rmq_pkg::*; #(
  parameter int unsigned NW = 26,
  parameter int unsigned SB = 13,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] rad_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [SB-1:0] root_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned TW = 2 * SB + 1;

  logic [SB-1:0] v_q;
  logic [TW-1:0] rem_q  [SB];
  logic [SB-1:0] root_q [SB];
  logic [SW-1:0] side_q [SB];

  // one result bit per stage, msb first
  for (genvar s = 0; s < SB; s++) begin : g_stage
    localparam int unsigned B = SB - 1 - s;
    logic [TW-1:0] rem_in, trial, rem_d;
    logic [SB-1:0] root_in, root_d;
    logic          v_in;
    logic [SW-1:0] side_in;

    if (s == 0) begin : g_first
      assign rem_in  = TW'(rad_i);
      assign root_in = '0;
      assign v_in    = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign v_in    = v_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (SB'(1) << B);
      end else begin
        rem_d  = rem_in;
        root_d = root_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[SB-1];
  assign root_o  = root_q[SB-1];
  assign side_o  = side_q[SB-1];

endmodule

// File: sv/rmq_div_lane.sv
`timescale 1ns / 1ps

module rmq_div_lane import rmq_pkg::*; #(
  parameter int unsigned F  = 14,
  parameter int unsigned SB = 13,
  parameter int unsigned DW = 32
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic        [SB-1:0]    root_i,
  output logic signed [15:0]      q_o
);

  localparam int unsigned NS = QBITS + 1;

  logic [DW-1:0]    rem_q [NS];
  logic [DW-1:0]    den_q [NS];
  logic [QBITS-1:0] quo_q [NS];
  logic [NS-1:0]    neg_q;
  logic [NS-1:0]    sat_q;

  logic [NUM_W-1:0] mag;
  logic [DW-1:0]    n0, d0;

  // numerator scaled, plus root for round to nearest
  always_comb begin
    mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
    n0  = (DW'(mag) << F) + DW'(root_i);
    d0  = DW'(root_i) << 1;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n0;
      den_q[0] <= d0;
      quo_q[0] <= '0;
      neg_q[0] <= num_i[NUM_W-1];
      sat_q[0] <= n0 >= (d0 << QBITS);
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int unsigned J = QBITS - k;
    logic [DW-1:0] sub;
    assign sub = den_q[k-1] << J;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
        sat_q[k] <= sat_q[k-1];
        if (!sat_q[k-1] && rem_q[k-1] >= sub) begin
          rem_q[k] <= rem_q[k-1] - sub;
          quo_q[k] <= quo_q[k-1] | (QBITS'(1) << J);
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
      end
    end
  end

  always_comb begin
    if (sat_q[NS-1]) begin
      q_o = neg_q[NS-1] ? 16'sh8000 : 16'sh7fff;
    end else if (neg_q[NS-1]) begin
      q_o = -$signed({1'b0, quo_q[NS-1]});
    end else begin
      q_o = $signed({1'b0, quo_q[NS-1]});
    end
  end

endmodule

// File: sv/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// channel | handshake                  | word
// in      | in_valid_i / in_stall_o    | in_data_i  (nine matrix elements)
// out     | out_valid_o / out_stall_i  | out_data_o (quaternion, case, flag)
// one matrix per cycle while the output word is not stalled; the pipeline runs through
// a decode register, the one-bit-per-stage square root (SB being the root width,
// (FRAC_BITS+RW+1)/2), the 16-stage quotient lanes and the output word register
// rst_ni clears only the valid bits of every stage
// a stalled output word freezes the whole pipeline; in_stall_o follows it

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned RW   = (F >= 17) ? F + 1 : 18;
  localparam int unsigned NW   = RW + F;
  localparam int unsigned SB   = (NW + 1) / 2;
  localparam int unsigned DW   = (F + 18 > SB + 16) ? F + 18 : SB + 16;
  localparam int unsigned SW   = 3 + 4 * NUM_W;
  localparam int unsigned LDV  = QBITS + 1;
  localparam int unsigned PSW  = 3 + 16;
  localparam int unsigned TRW  = 18;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // decode stage
  logic signed [TRW-1:0]   e00, e11, e22, trace, t;
  logic signed [NUM_W-1:0] num_d [4];
  case_e                   which_d;
  logic signed [RW:0]      r_s;
  logic                    bad_d;
  logic [NW-1:0]           rad_d;

  always_comb begin
    e00   = TRW'(in_data_i.m00);
    e11   = TRW'(in_data_i.m11);
    e22   = TRW'(in_data_i.m22);
    trace = e00 + e11 + e22;
    for (int k = 0; k < 4; k++) num_d[k] = '0;
    if (trace > 0) begin
      which_d  = CASE_TRACE;
      t        = trace;
      num_d[1] = NUM_W'(in_data_i.m21) - NUM_W'(in_data_i.m12);
      num_d[2] = NUM_W'(in_data_i.m02) - NUM_W'(in_data_i.m20);
      num_d[3] = NUM_W'(in_data_i.m10) - NUM_W'(in_data_i.m01);
    end else if (in_data_i.m00 > in_data_i.m11 && in_data_i.m00 > in_data_i.m22) begin
      which_d  = CASE_X;
      t        = e00 - e11 - e22;
      num_d[0] = NUM_W'(in_data_i.m21) - NUM_W'(in_data_i.m12);
      num_d[2] = NUM_W'(in_data_i.m01) + NUM_W'(in_data_i.m10);
      num_d[3] = NUM_W'(in_data_i.m02) + NUM_W'(in_data_i.m20);
    end else if (in_data_i.m11 > in_data_i.m22) begin
      which_d  = CASE_Y;
      t        = e11 - e00 - e22;
      num_d[0] = NUM_W'(in_data_i.m02) - NUM_W'(in_data_i.m20);
      num_d[1] = NUM_W'(in_data_i.m01) + NUM_W'(in_data_i.m10);
      num_d[3] = NUM_W'(in_data_i.m12) + NUM_W'(in_data_i.m21);
    end else begin
      which_d  = CASE_Z;
      t        = e22 - e00 - e11;
      num_d[0] = NUM_W'(in_data_i.m10) - NUM_W'(in_data_i.m01);
      num_d[1] = NUM_W'(in_data_i.m02) + NUM_W'(in_data_i.m20);
      num_d[2] = NUM_W'(in_data_i.m12) + NUM_W'(in_data_i.m21);
    end
    r_s   = $signed((RW + 1)'(1) << F) + (RW + 1)'(t);
    bad_d = r_s <= 0;
    // keep the root nonzero on a bad radicand, result is masked later
    rad_d = bad_d ? (NW'(1) << F) : (NW'(r_s[RW-1:0]) << F);
  end

  logic          dv_q;
  logic [NW-1:0] rad_q;
  logic [SW-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
    end else if (en) begin
      dv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q  <= rad_d;
      side_q <= {which_d, bad_d, num_d[0], num_d[1], num_d[2], num_d[3]};
    end
  end

  logic          sv_o;
  logic [SB-1:0] root;
  logic [SW-1:0] side_s;

  rmq_isqrt #(.NW(NW), .SB(SB), .SW(SW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_q),
    .rad_i   (rad_q),
    .side_i  (side_q),
    .valid_o (sv_o),
    .root_o  (root),
    .side_o  (side_s)
  );

  // diagonal component: (root + 1) >> 1, saturated
  logic [SB:0]          half;
  logic signed [15:0]   diag;
  always_comb begin
    half = ({1'b0, root} + (SB + 1)'(1)) >> 1;
    diag = (half > (SB + 1)'(16'h7fff)) ? 16'sh7fff : $signed(16'(half));
  end

  logic signed [15:0] quo [4];
  for (genvar k = 0; k < 4; k++) begin : g_lane
    rmq_div_lane #(.F(F), .SB(SB), .DW(DW)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (side_s[(3-k)*NUM_W +: NUM_W]),
      .root_i (root),
      .q_o    (quo[k])
    );
  end

  logic [LDV-1:0] pv_q;
  logic [PSW-1:0] ps_q [LDV];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[LDV-2:0], sv_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ps_q[0] <= {side_s[SW-1 -: 3], diag};
      for (int i = 1; i < LDV; i++) ps_q[i] <= ps_q[i-1];
    end
  end

  // output word register
  case_e              p_which;
  logic               p_bad;
  logic signed [15:0] p_diag;
  logic signed [15:0] qv [4];
  out_word_t          out_d, out_q;
  logic               ov_q;

  always_comb begin
    p_which = case_e'(ps_q[LDV-1][18:17]);
    p_bad   = ps_q[LDV-1][16];
    p_diag  = ps_q[LDV-1][15:0];
    for (int k = 0; k < 4; k++) begin
      if (p_bad) qv[k] = '0;
      else if (k == int'(p_which)) qv[k] = p_diag;
      else qv[k] = quo[k];
    end
    out_d.qw         = qv[0];
    out_d.qx         = qv[1];
    out_d.qy         = qv[2];
    out_d.qz         = qv[3];
    out_d.case_taken = p_which;
    out_d.bad_input  = p_bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= pv_q[LDV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_input |->
      out_data_o.qw == 0 && out_data_o.qx == 0 && out_data_o.qy == 0 && out_data_o.qz == 0)
    else $error("bad radicand word with nonzero quaternion");

  a_trace_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bad_input && out_data_o.case_taken == CASE_TRACE |->
      out_data_o.qw > 0)
    else $error("trace branch gave nonpositive w");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");
`endif

endmodule

// File: tb/tb_rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int N_RANDOM = 1300;
  localparam int CALM_TAIL = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_data_o;

  rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  typedef struct {
    in_word_t  mat;
    logic      fixed;
    out_word_t quat;
  } row_t;

  out_word_t expected_quats[$];
  int        n_errors;
  logic      sending_done;
  logic      calm;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // nearest, ties away from zero
  function automatic longint over_s(longint d, longint root);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = (mag * (longint'(1) << FRAC) + root) / (2 * root);
    return (d < 0) ? -q : q;
  endfunction

  function automatic out_word_t to_quaternion(in_word_t m);
    out_word_t q;
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint tr, rad, root;
    longint num[4];
    int k;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    num = '{0, 0, 0, 0};
    if (tr > 0) begin
      q.case_taken = CASE_TRACE;
      rad = (longint'(1) << FRAC) + tr;
      num[1] = a21 - a12; num[2] = a02 - a20; num[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      q.case_taken = CASE_X;
      rad = (longint'(1) << FRAC) + a00 - a11 - a22;
      num[0] = a21 - a12; num[2] = a01 + a10; num[3] = a02 + a20;
    end else if (a11 > a22) begin
      q.case_taken = CASE_Y;
      rad = (longint'(1) << FRAC) + a11 - a00 - a22;
      num[0] = a02 - a20; num[1] = a01 + a10; num[3] = a12 + a21;
    end else begin
      q.case_taken = CASE_Z;
      rad = (longint'(1) << FRAC) + a22 - a00 - a11;
      num[0] = a10 - a01; num[1] = a02 + a20; num[2] = a12 + a21;
    end
    q.qw = '0; q.qx = '0; q.qy = '0; q.qz = '0;
    q.bad_input = 1'b1;
    if (rad > 0) begin
      q.bad_input = 1'b0;
      root = longint'(int_root(64'(rad) << FRAC));
      for (k = 0; k < 4; k++) begin
        if (k == int'(q.case_taken)) num[k] = (root + 1) >>> 1;
        else num[k] = over_s(num[k], root);
      end
      q.qw = clamp16(num[0]); q.qx = clamp16(num[1]);
      q.qy = clamp16(num[2]); q.qz = clamp16(num[3]);
    end
    return q;
  endfunction

  function automatic in_word_t mk(int a, int b, int c, int d, int e, int f,
                                  int g, int h, int i);
    in_word_t m;
    m.m00 = 16'(a); m.m01 = 16'(b); m.m02 = 16'(c); m.m10 = 16'(d);
    m.m11 = 16'(e); m.m12 = 16'(f); m.m20 = 16'(g); m.m21 = 16'(h);
    m.m22 = 16'(i);
    return m;
  endfunction

  function automatic out_word_t qv(int w, int x, int y, int z, case_e c, logic b);
    out_word_t q;
    q.qw = 16'(w); q.qx = 16'(x); q.qy = 16'(y); q.qz = 16'(z);
    q.case_taken = c; q.bad_input = b;
    return q;
  endfunction

  function automatic logic signed [15:0] jiggle(logic signed [15:0] v);
    return 16'(int'(v) + int'($urandom_range(0, 8191)) - 4096);
  endfunction

  // near-rotation: random signed axis pattern with noise
  function automatic in_word_t rand_rotation();
    in_word_t m;
    int sel;
    int s0, s1;
    m = mk(0, 0, 0, 0, 0, 0, 0, 0, 0);
    sel = $urandom_range(0, 5);
    s0 = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    s1 = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
    case (sel)
      0: m = mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
      1: m = mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
      2: m = mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384);
      3: m = mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384);
      4: m = mk(0, s0, 0, s1, 0, 0, 0, 0, 16384);
      default: m = mk(0, 0, s0, 0, 16384, 0, s1, 0, 0);
    endcase
    m.m00 = jiggle(m.m00);
    m.m01 = jiggle(m.m01);
    m.m02 = jiggle(m.m02);
    m.m10 = jiggle(m.m10);
    m.m11 = jiggle(m.m11);
    m.m12 = jiggle(m.m12);
    m.m20 = jiggle(m.m20);
    m.m21 = jiggle(m.m21);
    m.m22 = jiggle(m.m22);
    return m;
  endfunction

  task automatic send_word(in_word_t m);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  row_t rows[$];

  task automatic add_row(in_word_t m, logic f, out_word_t q);
    row_t r;
    r.mat   = m;
    r.fixed = f;
    r.quat  = q;
    rows.insert(rows.size(), r);
  endtask

  initial begin
    in_word_t m;
    int k;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    n_errors     = 0;
    sending_done = 1'b0;
    calm         = 1'b0;
    add_row(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1'b1,
            qv(16384, 0, 0, 0, CASE_TRACE, 1'b0));
    add_row(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1'b1,
            qv(0, 16384, 0, 0, CASE_X, 1'b0));
    add_row(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1'b1,
            qv(0, 0, 16384, 0, CASE_Y, 1'b0));
    add_row(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1'b1,
            qv(0, 0, 0, 16384, CASE_Z, 1'b0));
    // all-zero matrix: tie on diagonals falls to the last branch, CASE_Z
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
            qv(0, 0, 0, 8192, CASE_Z, 1'b0));
    // most negative diagonals, large radicand
    add_row(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b0, '0);
    add_row(mk(-32768, 5, 6, 7, 32767, 8, 9, 10, 32767), 1'b0, '0);
    add_row(mk(32767, 0, 0, 0, -32768, 0, 0, 0, -32768), 1'b0, '0);
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
               32767), 1'b0, '0);
    add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
               -32768, -32768), 1'b0, '0);
    add_row(mk(1, 32767, -32768, -32768, -1, 32767, 32767, -32768, -1),
            1'b0, '0);
    // ties among diagonals
    add_row(mk(100, 1, 2, 3, 100, 4, 5, 6, -300), 1'b0, '0);
    add_row(mk(-300, 1, 2, 3, 100, 4, 5, 6, 100), 1'b0, '0);
    add_row(mk(100, 1, 2, 3, -300, 4, 5, 6, 100), 1'b0, '0);
    add_row(mk(-16384, 32767, -32768, 32767, -16384, -32768, 32767,
               32767, 16384), 1'b0, '0);
    add_row(mk(-21845, -21845, -21845, -21845, -21845, -21845, -21845,
               -21845, 21845), 1'b0, '0);
    add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(-16383, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      expected_quats.insert(expected_quats.size(),
                            rows[i].fixed ? rows[i].quat : to_quaternion(rows[i].mat));
      send_word(rows[i].mat);
    end
    for (k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM - CALM_TAIL) calm = 1'b1;
      if ($urandom_range(0, 3) != 0) m = rand_rotation();
      else m = in_word_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      expected_quats.insert(expected_quats.size(), to_quaternion(m));
      send_word(m);
    end
    in_valid_i   <= 1'b0;
    sending_done <= 1'b1;
  end

  // receiver side stall bursts
  initial begin
    int burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    while (!calm) begin
      @(posedge clk_i);
      if ($urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
    out_stall_i <= 1'b0;
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data_o);
        n_errors++;
      end else begin
        want = expected_quats.pop_front();
        if (out_data_o.qw !== want.qw) begin
          $display("%0t: qw expected %0d actual %0d", $time, want.qw, out_data_o.qw);
          n_errors++;
        end
        if (out_data_o.qx !== want.qx) begin
          $display("%0t: qx expected %0d actual %0d", $time, want.qx, out_data_o.qx);
          n_errors++;
        end
        if (out_data_o.qy !== want.qy) begin
          $display("%0t: qy expected %0d actual %0d", $time, want.qy, out_data_o.qy);
          n_errors++;
        end
        if (out_data_o.qz !== want.qz) begin
          $display("%0t: qz expected %0d actual %0d", $time, want.qz, out_data_o.qz);
          n_errors++;
        end
        if (out_data_o.case_taken !== want.case_taken) begin
          $display("%0t: case_taken expected %0d actual %0d", $time,
                   want.case_taken, out_data_o.case_taken);
          n_errors++;
        end
        if (out_data_o.bad_input !== want.bad_input) begin
          $display("%0t: bad_input expected %0d actual %0d", $time,
                   want.bad_input, out_data_o.bad_input);
          n_errors++;
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (expected_quats.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (n_errors == 0) $display("tb_rotation_matrix_to_quaternion: clean");
    else $display("tb_rotation_matrix_to_quaternion: errors");
    $finish;
  end

  initial begin
    #400000;
    $display("tb_rotation_matrix_to_quaternion: errors");
    $finish;
  end

endmodule

// File: sim.f
sv/rmq_pkg.sv
sv/rmq_isqrt.sv
sv/rmq_div_lane.sv
sv/rotation_matrix_to_quaternion.sv
tb/tb_rotation_matrix_to_quaternion.sv
